// ===== design/afc_pkg.sv =====
// Shared constants, types and helpers for the alpha flatten checkerboard block.
`default_nettype none

package afc_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int MAX_SAMPLE_BITS = 16;
    localparam int DEPTH_W         = 5;
    localparam int CUT_W           = 4;
    localparam int PROD_W          = 2 * SAMPLE_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int BG_W            = 3 * SAMPLE_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = BG_W;
    localparam int COORD_BITS_DEF  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CHECKER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_BG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECONDARY_BG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd5;

    localparam logic [DEPTH_W-1:0] SAMPLE_BITS_RST = 5'd8;

    // load strobes for the three lane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } lane_en_t;

    // depth clamped to 1..MAX_SAMPLE_BITS
    function automatic logic [DEPTH_W-1:0] depth_clamp(input logic [DEPTH_W-1:0] bits);
        logic [DEPTH_W-1:0] d;
        begin
            d = bits;
            if (bits == '0)
            begin
                d = DEPTH_W'(1);
            end
            else if (bits > DEPTH_W'(MAX_SAMPLE_BITS))
            begin
                d = DEPTH_W'(MAX_SAMPLE_BITS);
            end
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/afc_pixel_if.sv =====
// Input channel: one RGBA pixel per transaction.
`default_nettype none

interface afc_pixel_if import afc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
    logic [SAMPLE_W-1:0] alpha_in;
    logic                frame_start;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, frame_start,
                    input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, frame_start,
                    output ready);

endinterface

`default_nettype wire

// ===== design/afc_result_if.sv =====
// Output channel: one composited RGB pixel per transaction.
`default_nettype none

interface afc_result_if import afc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] red_out;
    logic [SAMPLE_W-1:0] green_out;
    logic [SAMPLE_W-1:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);

endinterface

`default_nettype wire

// ===== design/afc_position.sv =====
// Raster position tracker: column, square offsets and checkerboard parity.
`default_nettype none

module afc_position import afc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                frame_start,
    input  wire logic                checker_mode,
    input  wire logic [SAMPLE_W-1:0] square_size,
    input  wire logic [SAMPLE_W-1:0] line_width,
    output      logic                use_secondary
);

    localparam int CMP_W = ((COORD_BITS > SAMPLE_W) ? COORD_BITS : SAMPLE_W) + 1;

    logic [COORD_BITS-1:0] column_reg, column_next;
    logic [COORD_BITS-1:0] col_sq_reg, col_sq_next;
    logic [COORD_BITS-1:0] row_sq_reg, row_sq_next;
    logic                  col_par_reg, col_par_next;
    logic                  row_par_reg, row_par_next;

    logic [COORD_BITS-1:0] cur_col, cur_col_sq, cur_row_sq;
    logic                  cur_col_par, cur_row_par;
    logic [CMP_W-1:0]      col_p1, col_sq_p1, row_sq_p1, sq_ext, lw_ext;
    logic                  sq_on, col_sq_wrap, row_sq_wrap, line_end;

    // frame start clears the position before this pixel is used
    assign cur_col     = frame_start ? '0 : column_reg;
    assign cur_col_sq  = frame_start ? '0 : col_sq_reg;
    assign cur_row_sq  = frame_start ? '0 : row_sq_reg;
    assign cur_col_par = frame_start ? 1'b0 : col_par_reg;
    assign cur_row_par = frame_start ? 1'b0 : row_par_reg;

    assign sq_on  = (square_size != '0);
    assign sq_ext = CMP_W'(square_size);
    assign lw_ext = (line_width == '0) ? CMP_W'(1) : CMP_W'(line_width);

    assign col_p1    = CMP_W'(cur_col) + CMP_W'(1);
    assign col_sq_p1 = CMP_W'(cur_col_sq) + CMP_W'(1);
    assign row_sq_p1 = CMP_W'(cur_row_sq) + CMP_W'(1);

    assign col_sq_wrap = sq_on && (col_sq_p1 >= sq_ext);
    assign row_sq_wrap = sq_on && (row_sq_p1 >= sq_ext);
    assign line_end    = (col_p1 >= lw_ext);

    assign use_secondary = checker_mode && sq_on && !(cur_col_par ^ cur_row_par);

    always_comb
    begin
        if (line_end)
        begin
            column_next  = '0;
            col_sq_next  = '0;
            col_par_next = 1'b0;
            row_sq_next  = row_sq_wrap ? '0 : row_sq_p1[COORD_BITS-1:0];
            row_par_next = cur_row_par ^ row_sq_wrap;
        end
        else
        begin
            column_next  = col_p1[COORD_BITS-1:0];
            col_sq_next  = col_sq_wrap ? '0 : col_sq_p1[COORD_BITS-1:0];
            col_par_next = cur_col_par ^ col_sq_wrap;
            row_sq_next  = cur_row_sq;
            row_par_next = cur_row_par;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            col_sq_reg  <= '0;
            row_sq_reg  <= '0;
            col_par_reg <= 1'b0;
            row_par_reg <= 1'b0;
        end
        else if (step)
        begin
            column_reg  <= column_next;
            col_sq_reg  <= col_sq_next;
            row_sq_reg  <= row_sq_next;
            col_par_reg <= col_par_next;
            row_par_reg <= row_par_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/afc_blend_lane.sv =====
// One color channel of the blend: operand, product and sum stages.
`default_nettype none

module afc_blend_lane import afc_pkg::*;
(
    input  wire logic                clk,
    input  wire lane_en_t            en,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic [SAMPLE_W-1:0] mask,
    input  wire logic [SAMPLE_W-1:0] alpha,
    input  wire logic [SAMPLE_W-1:0] alpha_inv,
    input  wire logic [SAMPLE_W-1:0] bg16,
    input  wire logic [CUT_W-1:0]    bg_cut,
    output      logic [SUM_W-1:0]    sum
);

    logic [SAMPLE_W-1:0] c_reg, a_reg, inv_reg, bg_reg;
    logic [PROD_W-1:0]   fg_prod_reg, bg_prod_reg;
    logic [SUM_W-1:0]    sum_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            c_reg   <= sample & mask;
            a_reg   <= alpha;
            inv_reg <= alpha_inv;
            bg_reg  <= bg16 >> bg_cut;
        end
        if (en.s2)
        begin
            fg_prod_reg <= c_reg * a_reg;
            bg_prod_reg <= bg_reg * inv_reg;
        end
        if (en.s3)
        begin
            sum_reg <= SUM_W'(fg_prod_reg) + SUM_W'(bg_prod_reg);
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ===== design/alpha_flatten_checkerboard_unit.sv =====
// Top level: configuration registers, position tracker, three blend lanes, output merge.
`default_nettype none

// Composites one RGBA pixel per clock over a solid or checkerboard background
// while pix_out.ready stays high. A pixel passes from pix_in to pix_out through
// three stages in each color lane (operands, products, sum) and then the output
// register that shifts and merges the lanes. Stages advance independently, so
// pix_in.ready stays high while any stage ahead has room; with the output held,
// up to four pixels are in flight and pix_in.ready follows pix_out.ready.
// Configuration writes go through cfg_write/cfg_index/cfg_data and are meant
// for idle periods only.
module alpha_flatten_checkerboard_unit import afc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    afc_pixel_if.sink                  pix_in,
    afc_result_if.source               pix_out
);

    logic                checker_mode_reg;
    logic [SAMPLE_W-1:0] square_size_reg;
    logic [BG_W-1:0]     primary_bg_reg;
    logic [BG_W-1:0]     secondary_bg_reg;
    logic [DEPTH_W-1:0]  sample_bits_reg;
    logic [SAMPLE_W-1:0] line_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checker_mode_reg <= 1'b0;
            square_size_reg  <= '0;
            primary_bg_reg   <= '0;
            secondary_bg_reg <= '0;
            sample_bits_reg  <= SAMPLE_BITS_RST;
            line_width_reg   <= SAMPLE_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CHECKER_MODE: checker_mode_reg <= cfg_data[0];
                REG_SQUARE_SIZE:  square_size_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_PRIMARY_BG:   primary_bg_reg   <= cfg_data[BG_W-1:0];
                REG_SECONDARY_BG: secondary_bg_reg <= cfg_data[BG_W-1:0];
                REG_SAMPLE_BITS:  sample_bits_reg  <= cfg_data[DEPTH_W-1:0];
                REG_LINE_WIDTH:   line_width_reg   <= cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: each stage loads when its predecessor holds data and it has room
    logic     v1_reg, v2_reg, v3_reg, vo_reg;
    logic     ld1, ld2, ld3, ld_o;
    logic     free1, free2, free3, free_o;
    lane_en_t lane_en;

    assign free_o = !vo_reg || pix_out.ready;
    assign ld_o   = v3_reg && free_o;
    assign free3  = !v3_reg || ld_o;
    assign ld3    = v2_reg && free3;
    assign free2  = !v2_reg || ld3;
    assign ld2    = v1_reg && free2;
    assign free1  = !v1_reg || ld2;
    assign ld1    = pix_in.valid && free1;

    assign pix_in.ready = free1;
    assign lane_en      = '{s1: ld1, s2: ld2, s3: ld3};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ld1 || (v1_reg && !ld2);
            v2_reg <= ld2 || (v2_reg && !ld3);
            v3_reg <= ld3 || (v3_reg && !ld_o);
            vo_reg <= ld_o || (vo_reg && !pix_out.ready);
        end
    end

    // per-pixel shared operands
    logic [DEPTH_W-1:0]  depth;
    logic [SAMPLE_W-1:0] mask, alpha_m, alpha_inv;
    logic [CUT_W-1:0]    bg_cut;
    logic                use_secondary;
    logic [BG_W-1:0]     bg_word;

    assign depth     = depth_clamp(sample_bits_reg);
    assign mask      = SAMPLE_W'((SAMPLE_W + 1)'(1) << depth) - SAMPLE_W'(1);
    assign alpha_m   = pix_in.alpha_in & mask;
    assign alpha_inv = mask - alpha_m;
    assign bg_cut    = CUT_W'(DEPTH_W'(SAMPLE_W) - depth);
    assign bg_word   = use_secondary ? secondary_bg_reg : primary_bg_reg;

    afc_position #(.COORD_BITS(COORD_BITS)) u_position
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (ld1),
        .frame_start   (pix_in.frame_start),
        .checker_mode  (checker_mode_reg),
        .square_size   (square_size_reg),
        .line_width    (line_width_reg),
        .use_secondary (use_secondary)
    );

    logic [SUM_W-1:0] red_sum, green_sum, blue_sum;

    afc_blend_lane u_lane_red
    (
        .clk       (clk),
        .en        (lane_en),
        .sample    (pix_in.red_in),
        .mask      (mask),
        .alpha     (alpha_m),
        .alpha_inv (alpha_inv),
        .bg16      (bg_word[3*SAMPLE_W-1:2*SAMPLE_W]),
        .bg_cut    (bg_cut),
        .sum       (red_sum)
    );

    afc_blend_lane u_lane_green
    (
        .clk       (clk),
        .en        (lane_en),
        .sample    (pix_in.green_in),
        .mask      (mask),
        .alpha     (alpha_m),
        .alpha_inv (alpha_inv),
        .bg16      (bg_word[2*SAMPLE_W-1:SAMPLE_W]),
        .bg_cut    (bg_cut),
        .sum       (green_sum)
    );

    afc_blend_lane u_lane_blue
    (
        .clk       (clk),
        .en        (lane_en),
        .sample    (pix_in.blue_in),
        .mask      (mask),
        .alpha     (alpha_m),
        .alpha_inv (alpha_inv),
        .bg16      (bg_word[SAMPLE_W-1:0]),
        .bg_cut    (bg_cut),
        .sum       (blue_sum)
    );

    // merge: scale each lane sum back to the sample depth
    logic [SAMPLE_W-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk)
    begin
        if (ld_o)
        begin
            red_reg   <= SAMPLE_W'(red_sum >> depth);
            green_reg <= SAMPLE_W'(green_sum >> depth);
            blue_reg  <= SAMPLE_W'(blue_sum >> depth);
        end
    end

    assign pix_out.valid     = vo_reg;
    assign pix_out.red_out   = red_reg;
    assign pix_out.green_out = green_reg;
    assign pix_out.blue_out  = blue_reg;

endmodule

`default_nettype wire
